[sv/disparity_to_point_projection_defines.svh]
// Assertion macros for the disparity-to-point projection block.
// Included by every file that carries concurrent assertions.
`ifndef DISPARITY_TO_POINT_PROJECTION_DEFINES_SVH
`define DISPARITY_TO_POINT_PROJECTION_DEFINES_SVH

`ifndef ASSERT_OFF
`define DPP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DPP_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DPP_ASSERT(label, clk, rst, prop, msg)
`define DPP_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[sv/dpp_pkg.sv]
// Shared widths, reset values and register indices for the projection block.
// No dependencies; used by the channel interfaces, the top level and the bench.
`timescale 1ns / 1ps

package dpp_pkg;

  localparam int DISP_W     = 16;
  localparam int PIX_W      = 12;
  localparam int FOCAL_W    = 20;
  localparam int CENTER_W   = 20;
  localparam int BASE_W     = 24;
  localparam int MIND_W     = 15;
  localparam int DEPTH_W    = 24;
  localparam int COORD_W    = 32;
  localparam int DIV_W      = 15;
  localparam int DC_W       = 20;
  localparam int PROD_W     = 44;
  localparam int QUO_W      = 40;
  localparam int DIV_STAGES = QUO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [MIND_W-1:0]  MIN_DISP_RST  = 15'd160;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 24'd256000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL     = 3'd0,
    CFG_CENTER_X  = 3'd1,
    CFG_CENTER_Y  = 3'd2,
    CFG_BASELINE  = 3'd3,
    CFG_MIN_DISP  = 3'd4,
    CFG_MAX_DEPTH = 3'd5
  } cfg_idx_t;

endpackage

[sv/dpp_pixel_if.sv]
// Input channel: one disparity pixel per transaction.
// Depends on dpp_pkg for field widths.
`timescale 1ns / 1ps

interface dpp_pixel_if import dpp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disparity_raw;
  logic [PIX_W-1:0]         pixel_column;
  logic [PIX_W-1:0]         pixel_row;

  modport source (output valid, disparity_raw, pixel_column, pixel_row, input ready);
  modport sink   (input valid, disparity_raw, pixel_column, pixel_row, output ready);
endinterface

[sv/dpp_point_if.sv]
// Output channel: one 3D point per transaction.
// Depends on dpp_pkg for field widths.
`timescale 1ns / 1ps

interface dpp_point_if import dpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [DEPTH_W-1:0]        point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[sv/disparity_to_point_projection.sv]
// Stereo disparity to 3D point reprojection, fully pipelined.
// Depends on dpp_pkg, dpp_pixel_if, dpp_point_if and the assertion defines header.
//
// One pixel is accepted every clock unless the output stalls. A pixel passes input decode,
// three parallel 24x20 products, a 40-stage restoring divider that resolves one quotient bit
// per stage for Z, X and Y together, then range check and saturation into the output register.
// The whole pipeline holds while a finished point waits, so ready follows the output side. Pixels
// whose disparity is at or below min_disparity, or whose depth is zero or not below max_depth,
// produce no point. Registers must be written only while the pipeline is empty; it is not enforced.
`timescale 1ns / 1ps
`include "disparity_to_point_projection_defines.svh"

module disparity_to_point_projection import dpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  dpp_pixel_if.sink             pixel_in,
  dpp_point_if.source           point_out
);

  typedef struct packed {
    logic [DIV_W-1:0] d;
    logic [DC_W-1:0]  magx;
    logic             negx;
    logic [DC_W-1:0]  magy;
    logic             negy;
  } front_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] acc;
  } lane_t;

  typedef struct packed {
    logic [DIV_W-1:0] d;
    logic             negx;
    logic             negy;
    lane_t            lx;
    lane_t            ly;
    lane_t            lz;
  } div_stage_t;

  function automatic lane_t lane_step(lane_t l, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    logic           ge;
    lane_t          r;
    t    = {l.rem, l.acc[QUO_W-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    r.rem = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
    r.acc = {l.acc[QUO_W-2:0], ge};
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_axis(logic [QUO_W-1:0] q, logic neg);
    logic [COORD_W-1:0] r;
    if (neg) begin
      if (q >= QUO_W'(64'h8000_0000)) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(0) - q[COORD_W-1:0];
      end
    end else begin
      if (q > QUO_W'(64'h7FFF_FFFF)) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = q[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  logic [FOCAL_W-1:0]  focal_length;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [BASE_W-1:0]   baseline;
  logic [MIND_W-1:0]   min_disparity;
  logic [DEPTH_W-1:0]  max_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length  <= '0;
      center_x      <= '0;
      center_y      <= '0;
      baseline      <= '0;
      min_disparity <= MIN_DISP_RST;
      max_depth     <= MAX_DEPTH_RST;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_FOCAL:     focal_length  <= wr_data[FOCAL_W-1:0];
        CFG_CENTER_X:  center_x      <= wr_data[CENTER_W-1:0];
        CFG_CENTER_Y:  center_y      <= wr_data[CENTER_W-1:0];
        CFG_BASELINE:  baseline      <= wr_data[BASE_W-1:0];
        CFG_MIN_DISP:  min_disparity <= wr_data[MIND_W-1:0];
        CFG_MAX_DEPTH: max_depth     <= wr_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv            = !point_out.valid || point_out.ready;
  assign pixel_in.ready = adv;

  logic                pass;
  logic [DC_W:0]       dcx;
  logic [DC_W:0]       dcy;
  front_t              front_next;

  always_comb begin
    pass = $signed(pixel_in.disparity_raw) > $signed({1'b0, min_disparity});
    dcx  = {1'b0, pixel_in.pixel_column, 8'b0} - {1'b0, center_x};
    dcy  = {1'b0, pixel_in.pixel_row, 8'b0} - {1'b0, center_y};
    front_next.d    = pixel_in.disparity_raw[DIV_W-1:0];
    front_next.negx = dcx[DC_W];
    front_next.magx = dcx[DC_W] ? DC_W'(-dcx) : dcx[DC_W-1:0];
    front_next.negy = dcy[DC_W];
    front_next.magy = dcy[DC_W] ? DC_W'(-dcy) : dcy[DC_W-1:0];
  end

  logic   front_vld;
  front_t front;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_vld <= 1'b0;
    end else if (adv) begin
      front_vld <= pixel_in.valid && pass;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front <= front_next;
    end
  end

  logic [PROD_W-1:0] xprod;
  logic [PROD_W-1:0] yprod;
  logic [PROD_W-1:0] zprod;

  always_comb begin
    xprod = PROD_W'(front.magx) * PROD_W'(baseline);
    yprod = PROD_W'(front.magy) * PROD_W'(baseline);
    zprod = PROD_W'(baseline) * PROD_W'(focal_length);
  end

  logic [DIV_STAGES:0] stg_vld;
  div_stage_t          stg [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else if (adv) begin
      stg_vld <= {stg_vld[DIV_STAGES-1:0], front_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].d      <= front.d;
      stg[0].negx   <= front.negx;
      stg[0].negy   <= front.negy;
      stg[0].lx.rem <= '0;
      stg[0].lx.acc <= xprod[PROD_W-1:PROD_W-QUO_W];
      stg[0].ly.rem <= '0;
      stg[0].ly.acc <= yprod[PROD_W-1:PROD_W-QUO_W];
      stg[0].lz.rem <= '0;
      stg[0].lz.acc <= zprod[PROD_W-1:PROD_W-QUO_W];
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg[k+1].d    <= stg[k].d;
        stg[k+1].negx <= stg[k].negx;
        stg[k+1].negy <= stg[k].negy;
        stg[k+1].lx   <= lane_step(stg[k].lx, stg[k].d);
        stg[k+1].ly   <= lane_step(stg[k].ly, stg[k].d);
        stg[k+1].lz   <= lane_step(stg[k].lz, stg[k].d);
      end
    end
  end

  logic [QUO_W-1:0] zq;
  logic             keep;
  assign zq   = stg[DIV_STAGES].lz.acc;
  assign keep = stg_vld[DIV_STAGES] && (zq != '0) && (zq < QUO_W'(max_depth));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_out.valid <= 1'b0;
    end else if (adv) begin
      point_out.valid <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_out.point_x <= sat_axis(stg[DIV_STAGES].lx.acc, stg[DIV_STAGES].negx);
      point_out.point_y <= sat_axis(stg[DIV_STAGES].ly.acc, stg[DIV_STAGES].negy);
      point_out.point_z <= zq[DEPTH_W-1:0];
    end
  end

  `DPP_ASSERT(a_hold_on_stall, clk, rst, !adv |=> $stable(stg_vld) && $stable(front_vld), "pipeline moved while the output was stalled")
  `DPP_ASSERT(a_depth_range, clk, rst, point_out.valid |-> (point_out.point_z != '0) && (point_out.point_z < max_depth), "point leaves with depth out of range")
  `DPP_ASSERT(a_reject_small, clk, rst, (pixel_in.valid && pixel_in.ready && ($signed(pixel_in.disparity_raw) <= $signed({1'b0, min_disparity}))) |=> !front_vld, "small disparity entered the pipeline")
  `DPP_ASSERT(a_out_from_pipe, clk, rst, $rose(point_out.valid) |-> $past(stg_vld[DIV_STAGES]), "point appeared without a divider result")

endmodule

[bench/testbench.sv]
// Self-checking bench for disparity_to_point_projection: pixel driver, point monitor,
// predictor of the triangulated point and register programming over several setups.
// Depends on dpp_pkg, dpp_pixel_if, dpp_point_if and the block itself.
`timescale 1ns / 1ps

module testbench;
  import dpp_pkg::*;

  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_SETUPS  = 8;
  localparam int PIXELS_PER_SETUP = 160;
  localparam int MAX_PRINTED    = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic signed [DISP_W-1:0] disparity;
    logic [PIX_W-1:0]         column;
    logic [PIX_W-1:0]         row;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
  } point_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  dpp_pixel_if pix_if ();
  dpp_point_if pt_if ();

  disparity_to_point_projection u_top (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pixel_in  (pix_if),
    .point_out (pt_if)
  );

  // Predictor copy of the registers
  logic [FOCAL_W-1:0]  focal_q;
  logic [CENTER_W-1:0] centre_x_q;
  logic [CENTER_W-1:0] centre_y_q;
  logic [BASE_W-1:0]   baseline_q;
  logic [MIND_W-1:0]   min_disp_q;
  logic [DEPTH_W-1:0]  max_depth_q;

  pixel_t pixels_to_send[$];
  point_t expected_points[$];
  pixel_t cur_pixel;

  int pixels_queued;
  int pixels_accepted;
  int points_predicted;
  int points_checked;
  int mismatches;
  int setups;
  int src_idle_pct;
  int snk_stall_pct;
  int src_calm;
  int snk_calm;
  bit src_skip;
  bit snk_skip;
  int quiet_cycles;
  int win_lo;
  int win_hi;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] axis_coord(input logic [PIX_W-1:0] pix,
                                                    input logic [CENTER_W-1:0] centre,
                                                    input longint unsigned div);
    longint offset;
    longint unsigned mag;
    longint unsigned quo;
    offset = longint'({pix, 8'h00}) - longint'(centre);
    mag = (offset < 0) ? longint'(-offset) : longint'(offset);
    quo = (mag * 64'(baseline_q)) / div;
    if (offset < 0) begin
      if (quo >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return quo[COORD_W-1:0];
  endfunction

  function automatic bit project_pixel(input pixel_t px, output point_t pt);
    longint d;
    longint unsigned div;
    longint unsigned depth;
    pt = '0;
    d = longint'(px.disparity);
    if (d <= longint'(min_disp_q)) return 1'b0;
    div = 64'(16 * d);
    depth = (64'(baseline_q) * 64'(focal_q)) / div;
    if (depth == 0 || depth >= 64'(max_depth_q)) return 1'b0;
    pt.x = axis_coord(px.column, centre_x_q, div);
    pt.y = axis_coord(px.row, centre_y_q, div);
    pt.z = depth[DEPTH_W-1:0];
    return 1'b1;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      CFG_FOCAL:     focal_q     = data[FOCAL_W-1:0];
      CFG_CENTER_X:  centre_x_q  = data[CENTER_W-1:0];
      CFG_CENTER_Y:  centre_y_q  = data[CENTER_W-1:0];
      CFG_BASELINE:  baseline_q  = data[BASE_W-1:0];
      CFG_MIN_DISP:  min_disp_q  = data[MIND_W-1:0];
      CFG_MAX_DEPTH: max_depth_q = data[DEPTH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic program_setup(input logic [CFG_DATA_W-1:0] f, cx, cy, b, mn, md);
    write_reg(CFG_FOCAL, f);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_BASELINE, b);
    write_reg(CFG_MIN_DISP, mn);
    write_reg(CFG_MAX_DEPTH, md);
    setups++;
  endtask

  task automatic queue_pixel(input int d, input int col, input int row);
    pixel_t px;
    px.disparity = d[DISP_W-1:0];
    px.column    = col[PIX_W-1:0];
    px.row       = row[PIX_W-1:0];
    pixels_to_send.push_back(px);
    pixels_queued++;
  endtask

  // Wait for every pixel and point, then let rejected pixels leave the pipeline
  task automatic settle();
    while (pixels_accepted != pixels_queued || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(input int width);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = (24'd1 << width) - 24'd1;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = mask;
      default: v = ($urandom() & mask) >> $urandom_range(0, width - 1);
    endcase
    return v;
  endfunction

  // Pick a random setup, preferring one where some disparities give a point
  task automatic choose_setup();
    logic [CFG_DATA_W-1:0] f, cx, cy, b, mn, md;
    longint unsigned bf;
    longint unsigned lo;
    longint unsigned hi;
    int tries;
    tries = 0;
    win_lo = 1;
    win_hi = 0;
    while (win_lo > win_hi && tries < 50) begin
      f  = pick_value(FOCAL_W);
      cx = pick_value(CENTER_W);
      cy = pick_value(CENTER_W);
      b  = pick_value(BASE_W);
      mn = ($urandom_range(0, 9) == 0) ? pick_value(MIND_W) : $urandom_range(0, 3000);
      md = pick_value(DEPTH_W);
      bf = 64'(b) * 64'(f);
      lo = (md == 0) ? 64'd40000 : bf / (64'd16 * 64'(md)) + 1;
      if (lo < 64'(mn) + 1) lo = 64'(mn) + 1;
      hi = bf / 16;
      if (hi > 32767) hi = 32767;
      win_lo = (lo > 32768) ? 32768 : int'(lo);
      win_hi = int'(hi);
      tries++;
    end
    program_setup(f, cx, cy, b, mn, md);
  endtask

  task automatic queue_random_pixel();
    int sel;
    int d;
    sel = $urandom_range(0, 99);
    if (win_lo <= win_hi && sel < 80) begin
      d = $urandom_range(win_lo, win_hi);
    end else if (sel < 88) begin
      case ($urandom_range(0, 5))
        0: d = win_lo - 1;
        1: d = win_lo;
        2: d = win_hi;
        3: d = win_hi + 1;
        4: d = int'(min_disp_q);
        default: d = int'(min_disp_q) + 1;
      endcase
    end else begin
      d = $urandom_range(0, 65535);
    end
    queue_pixel(d, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        point_t pt;
        if (project_pixel(cur_pixel, pt)) begin
          expected_points.push_back(pt);
          points_predicted++;
        end
        pixels_accepted++;
      end
      if (src_calm > 0) src_calm--;
      else if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(8, 40);
      src_skip = (src_calm == 0) && ($urandom_range(0, 99) < src_idle_pct);
      if (!pix_if.valid || pix_if.ready) begin
        if (pixels_to_send.size() > 0 && !src_skip) begin
          cur_pixel = pixels_to_send.pop_front();
          pix_if.valid         <= 1'b1;
          pix_if.disparity_raw <= cur_pixel.disparity;
          pix_if.pixel_column  <= cur_pixel.column;
          pix_if.pixel_row     <= cur_pixel.row;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Point monitor
  always @(posedge clk) begin
    if (rst) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        point_t exp_pt;
        if (expected_points.size() == 0) begin
          report($sformatf("point (%0d, %0d, %0d) with none expected",
                           pt_if.point_x, pt_if.point_y, pt_if.point_z));
        end else begin
          exp_pt = expected_points.pop_front();
          if (pt_if.point_x !== exp_pt.x)
            report($sformatf("point_x %0d, expected %0d", pt_if.point_x, exp_pt.x));
          if (pt_if.point_y !== exp_pt.y)
            report($sformatf("point_y %0d, expected %0d", pt_if.point_y, exp_pt.y));
          if (pt_if.point_z !== exp_pt.z)
            report($sformatf("point_z %0d, expected %0d", pt_if.point_z, exp_pt.z));
        end
        points_checked++;
      end
      if (snk_calm > 0) snk_calm--;
      else if ($urandom_range(0, 49) == 0) snk_calm = $urandom_range(8, 40);
      snk_skip = (snk_calm == 0) && ($urandom_range(0, 99) < snk_stall_pct);
      pt_if.ready <= !snk_skip;
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (pt_if.valid && pt_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    int n;
    rst                  = 1'b1;
    wr_en                = 1'b0;
    wr_index             = '0;
    wr_data              = '0;
    pix_if.valid         = 1'b0;
    pix_if.disparity_raw = '0;
    pix_if.pixel_column  = '0;
    pix_if.pixel_row     = '0;
    pt_if.ready          = 1'b0;
    focal_q     = '0;
    centre_x_q  = '0;
    centre_y_q  = '0;
    baseline_q  = '0;
    min_disp_q  = MIN_DISP_RST;
    max_depth_q = MAX_DEPTH_RST;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setup: zero focal length and baseline give zero depth
    queue_pixel(32767, 4095, 4095);
    queue_pixel(161, 0, 0);
    queue_pixel(160, 1, 1);
    queue_pixel(-1, 2048, 2048);
    settle();

    // Typical camera: rejection below and at the minimum, far depth, both image edges
    program_setup(24'd179200, 24'd163840, 24'd92160, 24'd25600, 24'd160, 24'd256000);
    queue_pixel(-32768, 0, 0);
    queue_pixel(0, 100, 100);
    queue_pixel(160, 640, 360);
    queue_pixel(161, 640, 360);
    queue_pixel(1000, 10, 10);
    queue_pixel(1120, 0, 0);
    queue_pixel(1121, 0, 0);
    queue_pixel(32767, 4095, 4095);
    queue_pixel(2000, 4095, 0);
    queue_pixel(2000, 0, 4095);
    queue_pixel(16384, 2048, 1024);
    queue_pixel(32767, 640, 360);
    settle();

    // Saturation of both coordinates in both directions
    program_setup(24'd1, 24'd0, 24'hFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
    queue_pixel(1, 4095, 0);
    queue_pixel(512, 4095, 0);
    queue_pixel(32767, 0, 4095);
    queue_pixel(0, 1, 1);
    queue_pixel(-1, 1, 1);
    settle();
    // Writes beyond the register list must change nothing
    write_reg(CFG_UNMAPPED_LO, 24'hFFFFFF);
    write_reg(CFG_UNMAPPED_HI, 24'h000000);
    queue_pixel(1, 4095, 4095);
    settle();

    // Largest minimum disparity rejects everything
    write_reg(CFG_MIN_DISP, 24'h7FFF);
    queue_pixel(32767, 4095, 4095);
    queue_pixel(-32768, 0, 0);
    settle();

    for (p = 0; p < RANDOM_SETUPS; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 28; snk_stall_pct = 28; end
      endcase
      choose_setup();
      for (n = 0; n < PIXELS_PER_SETUP; n++) queue_random_pixel();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_points.size() > 0) begin
      point_t left;
      left = expected_points.pop_front();
      report($sformatf("point (%0d, %0d, %0d) never arrived", left.x, left.y, left.z));
    end

    $display("Projected %0d pixels over %0d register setups with four idling patterns.",
             pixels_accepted, setups);
    $display("%0d points compared, %0d pixels rejected, %0d mismatches.",
             points_checked, pixels_accepted - points_predicted, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[disparity_to_point_projection.f]
+incdir+sv
sv/dpp_pkg.sv
sv/dpp_pixel_if.sv
sv/dpp_point_if.sv
sv/disparity_to_point_projection.sv
bench/testbench.sv
